// ===== src/psfc_pkg.sv =====
package psfc_pkg;

    // Request opcodes
    localparam logic [1:0] OP_SINGLE     = 2'd0;
    localparam logic [1:0] OP_AVG_SAMPLE = 2'd1;
    localparam logic [1:0] OP_AVG_FINISH = 2'd2;
    localparam logic [1:0] OP_CAL_SAMPLE = 2'd3;

    // Config register indexes
    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_PMIN      = 2'd1;
    localparam logic [1:0] REG_OFFSET    = 2'd2;
    localparam logic [1:0] REG_AVG_COUNT = 2'd3;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int PCOUNT_W    = 16;
    localparam int TCOUNT_W    = 11;
    localparam int SUM_W       = 24;
    localparam int CAL_SUM_W   = 20;
    localparam int DEN_W       = 8;
    localparam int TEMP_W      = 25;

    localparam int CAL_SAMPLES_DEF = 10;
    localparam int Q_DEPTH         = 2;

    localparam logic [12:0]       TEMP_SCALE = 13'd6403;
    localparam logic [TEMP_W-1:0] TEMP_BIAS  = 25'd3276800;
    localparam logic signed [31:0] DEAD_BAND = 32'sd327680;

    typedef struct packed {
        logic [1:0]          op;
        logic [PCOUNT_W-1:0] pcount;
        logic [TCOUNT_W-1:0] tcount;
    } entry_t;

    typedef struct packed {
        logic   full;
        logic   empty;
        entry_t head;
    } q_stat_t;

endpackage

// ===== src/pressure_sensor_frame_conditioner.sv =====
// Pressure sensor frame conditioner. Each request carries one four-byte
// sensor frame and an opcode: single read (one result), average sample
// (pressure count added to a running sum, no result), average finish (sum
// divided by average_count, temperature taken from this frame, sum cleared,
// one result) and calibration sample (CAL_SAMPLES frames averaged into the
// zero offset, no result). Pressure results are signed Q16.16, saturated and
// forced to zero strictly inside +/-5.0; temperature is count*6403 - 50.0 in
// Q9.16. A front stage latches each request and splits the frame into
// counts, a two-entry queue decouples it from the back end, and the back end
// runs one request at a time: an average sample or a non-final calibration
// sample only updates running state, a single read goes through multiply,
// add/saturate and output load, and an average finish or final calibration
// sample first runs the 24-step radix-2 divider (the final calibration
// sample has no output load). Results sit in an output register, so the back
// end keeps working while a result waits, up to its own output load. Config
// writes take effect at once and are meant to be issued only while idle.
module pressure_sensor_frame_conditioner
#(
    parameter int CAL_SAMPLES = psfc_pkg::CAL_SAMPLES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [psfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psfc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [7:0]                      byte_one,
    input  logic [7:0]                      byte_two,
    input  logic [7:0]                      byte_three,
    input  logic [7:0]                      byte_four,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [31:0]              pressure_value,
    output logic signed [psfc_pkg::TEMP_W-1:0] temperature_value,
    output logic [psfc_pkg::PCOUNT_W-1:0]   pressure_raw,
    output logic [psfc_pkg::TCOUNT_W-1:0]   temperature_raw
);
    import psfc_pkg::*;

    q_stat_t qs;
    logic    push;
    entry_t  push_entry;
    logic    pop;

    // request intake and frame split
    psfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .byte_one   (byte_one),
        .byte_two   (byte_two),
        .byte_three (byte_three),
        .byte_four  (byte_four),
        .qs         (qs),
        .push       (push),
        .push_entry (push_entry)
    );

    // decoupling queue
    psfc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .qs         (qs)
    );

    // divide, convert, calibrate, output register
    psfc_back
    #(
        .CAL_SAMPLES (CAL_SAMPLES)
    )
    u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .qs                (qs),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pressure_value    (pressure_value),
        .temperature_value (temperature_value),
        .pressure_raw      (pressure_raw),
        .temperature_raw   (temperature_raw)
    );

    // queue cannot report full and empty together
    a_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(qs.full && qs.empty))
        else $error("queue full and empty at once");

    // intake only stalls on a full queue
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> qs.full)
        else $error("intake stalled with queue space");

    // back end never pops an empty queue
    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qs.empty)
        else $error("pop from empty queue");

    // queue push while full would lose a request
    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qs.full)
        else $error("push into full queue");

endmodule

// ===== src/psfc_front.sv =====
module psfc_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           opcode,
    input  logic [7:0]           byte_one,
    input  logic [7:0]           byte_two,
    input  logic [7:0]           byte_three,
    input  logic [7:0]           byte_four,
    input  psfc_pkg::q_stat_t    qs,
    output logic                 push,
    output psfc_pkg::entry_t     push_entry
);
    import psfc_pkg::*;

    logic   fe_valid_reg;
    logic   fe_valid_next;
    entry_t fe_entry_reg;
    logic   accept;

    assign in_stall   = fe_valid_reg && qs.full;
    assign accept     = in_valid && !in_stall;
    assign push       = fe_valid_reg && !qs.full;
    assign push_entry = fe_entry_reg;

    always_comb
    begin
        fe_valid_next = fe_valid_reg;
        if (accept)
        begin
            fe_valid_next = 1'b1;
        end
        else if (push)
        begin
            fe_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fe_valid_reg <= 1'b0;
        end
        else
        begin
            fe_valid_reg <= fe_valid_next;
        end
    end

    // Split frame into counts; temperature count drops the low five bits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fe_entry_reg.op     <= opcode;
            fe_entry_reg.pcount <= {byte_one, byte_two};
            fe_entry_reg.tcount <= {byte_three, byte_four[7:5]};
        end
    end

endmodule

// ===== src/psfc_queue.sv =====
module psfc_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  psfc_pkg::entry_t  push_entry,
    input  logic              pop,
    output psfc_pkg::q_stat_t qs
);
    import psfc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    entry_t             mem [Q_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign qs.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign qs.empty = (count_reg == '0);
    assign qs.head  = mem[rd_ptr_reg];

    assign do_push = push && !qs.full;
    assign do_pop  = pop && !qs.empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/psfc_back.sv =====
module psfc_back
#(
    parameter int CAL_SAMPLES = psfc_pkg::CAL_SAMPLES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [psfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [psfc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  psfc_pkg::q_stat_t          qs,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         pressure_value,
    output logic signed [psfc_pkg::TEMP_W-1:0] temperature_value,
    output logic [psfc_pkg::PCOUNT_W-1:0]      pressure_raw,
    output logic [psfc_pkg::TCOUNT_W-1:0]      temperature_raw
);
    import psfc_pkg::*;

    localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SUM  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    // config
    logic signed [31:0] gain_reg;
    logic signed [15:0] pmin_reg;
    logic signed [15:0] offset_reg;
    logic [DEN_W-1:0]   avg_count_reg;

    // running state
    logic [SUM_W-1:0]     sample_sum_reg;
    logic [CAL_SUM_W-1:0] cal_sum_reg;
    logic [CNT_W-1:0]     cal_cnt_reg;
    logic signed [31:0]   zero_reg;

    // datapath
    logic [2:0]           state_reg;
    logic [1:0]           op_reg;
    logic [PCOUNT_W-1:0]  praw_reg;
    logic [TCOUNT_W-1:0]  traw_reg;
    logic [SUM_W-1:0]     num_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DEN_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [49:0]   prod_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [31:0]   pres_reg;
    logic                 out_valid_reg;

    logic [SUM_W:0]       sum_add;
    logic [CAL_SUM_W:0]   cal_add;
    logic [CAL_SUM_W-1:0] cal_sum_sat;
    logic [CNT_W-1:0]     cal_cnt_inc;
    logic [DEN_W:0]       rem_shift;
    logic                 q_bit;
    logic signed [17:0]   diff;
    logic signed [51:0]   total;
    logic signed [31:0]   total_sat;
    logic                 out_free;

    assign pop      = (state_reg == S_IDLE) && !qs.empty;
    assign out_free = !out_valid_reg || !out_stall;

    assign sum_add     = {1'b0, sample_sum_reg} + {{(SUM_W + 1 - PCOUNT_W){1'b0}}, qs.head.pcount};
    assign cal_add     = {1'b0, cal_sum_reg} + {{(CAL_SUM_W + 1 - PCOUNT_W){1'b0}}, qs.head.pcount};
    assign cal_sum_sat = cal_add[CAL_SUM_W] ? '1 : cal_add[CAL_SUM_W-1:0];
    assign cal_cnt_inc = cal_cnt_reg + 1'b1;

    // one restoring divide step; remainder stays below the divisor
    assign rem_shift = {rem_reg, num_reg[SUM_W-1]};
    assign q_bit     = (rem_shift >= {1'b0, den_reg});

    assign diff = $signed({2'b00, praw_reg}) - $signed({{2{offset_reg[15]}}, offset_reg});

    always_comb
    begin
        total = $signed({{2{prod_reg[49]}}, prod_reg})
              + $signed({{20{pmin_reg[15]}}, pmin_reg, 16'h0000});
        if (op_reg != OP_CAL_SAMPLE)
        begin
            total = total - $signed({{20{zero_reg[31]}}, zero_reg});
        end
        if (total[51:31] == {21{total[51]}})
        begin
            total_sat = total[31:0];
        end
        else if (total[51])
        begin
            total_sat = 32'sh8000_0000;
        end
        else
        begin
            total_sat = 32'sh7FFF_FFFF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg       <= 32'sd65536;
            pmin_reg       <= '0;
            offset_reg     <= '0;
            avg_count_reg  <= DEN_W'(1);
            sample_sum_reg <= '0;
            cal_sum_reg    <= '0;
            cal_cnt_reg    <= '0;
            zero_reg       <= '0;
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN:      gain_reg      <= cfg_data;
                    REG_PMIN:      pmin_reg      <= cfg_data[15:0];
                    REG_OFFSET:    offset_reg    <= cfg_data[15:0];
                    REG_AVG_COUNT: avg_count_reg <= cfg_data[DEN_W-1:0];
                    default:       ;
                endcase
            end

            if (state_reg == S_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        unique case (qs.head.op)
                            OP_SINGLE:
                            begin
                                state_reg <= S_MUL;
                            end
                            OP_AVG_SAMPLE:
                            begin
                                sample_sum_reg <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                            end
                            OP_AVG_FINISH:
                            begin
                                sample_sum_reg <= '0;
                                state_reg      <= S_DIV;
                            end
                            OP_CAL_SAMPLE:
                            begin
                                if (cal_cnt_inc >= CNT_W'(CAL_SAMPLES))
                                begin
                                    cal_sum_reg <= '0;
                                    cal_cnt_reg <= '0;
                                    state_reg   <= S_DIV;
                                end
                                else
                                begin
                                    cal_sum_reg <= cal_sum_sat;
                                    cal_cnt_reg <= cal_cnt_inc;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (op_reg == OP_CAL_SAMPLE)
                    begin
                        zero_reg  <= total_sat;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg      <= qs.head.op;
            praw_reg    <= qs.head.pcount;
            traw_reg    <= qs.head.tcount;
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(SUM_W - 1);
            if (qs.head.op == OP_CAL_SAMPLE)
            begin
                num_reg <= {{(SUM_W - CAL_SUM_W){1'b0}}, cal_sum_sat};
                den_reg <= DEN_W'(CAL_SAMPLES);
            end
            else
            begin
                num_reg <= sample_sum_reg;
                den_reg <= (avg_count_reg == '0) ? DEN_W'(1) : avg_count_reg;
            end
        end

        if (state_reg == S_DIV)
        begin
            rem_reg     <= q_bit ? DEN_W'(rem_shift - {1'b0, den_reg}) : rem_shift[DEN_W-1:0];
            num_reg     <= {num_reg[SUM_W-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == '0)
            begin
                // quotient is complete with this bit; clamp to 16 bits
                if (num_reg[SUM_W-2:PCOUNT_W-1] != '0)
                begin
                    praw_reg <= '1;
                end
                else
                begin
                    praw_reg <= {num_reg[PCOUNT_W-2:0], q_bit};
                end
            end
        end

        if (state_reg == S_MUL)
        begin
            prod_reg <= diff * gain_reg;
            temp_reg <= $signed(TEMP_W'(traw_reg) * TEMP_W'(TEMP_SCALE) - TEMP_BIAS);
        end

        if (state_reg == S_SUM)
        begin
            if (total_sat > -DEAD_BAND && total_sat < DEAD_BAND)
            begin
                pres_reg <= '0;
            end
            else
            begin
                pres_reg <= total_sat;
            end
        end

        if (state_reg == S_OUT && out_free)
        begin
            pressure_value    <= pres_reg;
            temperature_value <= temp_reg;
            pressure_raw      <= praw_reg;
            temperature_raw   <= traw_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
